// ===== hw/rtl/sbs_pkg.sv =====
// ============================================================================
// sbs_pkg
// Shared types, constants and helper functions of the service backend selector.
// ============================================================================
package sbs_pkg;

    // Default table depths
    localparam int DEF_SERVICE_ENTRIES = 16;
    localparam int DEF_BACKEND_ENTRIES = 256;

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    // Protocols that keep their ports
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Stream widths
    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 64;

    // Pipeline shape: capture, match, four more hash mixes, eight modulo
    // stages of four bits each, backend read
    localparam int STG_MATCH   = 1;
    localparam int STG_MIX_END = 5;
    localparam int STG_MOD_END = 13;
    localparam int STG_READ    = 14;
    localparam int N_STG       = 15;

    typedef enum logic [1:0] {
        CMD_CLASSIFY = 2'd0,
        CMD_SVC_WR   = 2'd1,
        CMD_BE_WR    = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_PASS    = 2'd0,
        VERDICT_REWRITE = 2'd1,
        VERDICT_DROP    = 2'd2
    } t_verdict;

    // One item as it travels down the pipeline
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [15:0] hc;
        logic [8:0]  total;
        logic [31:0] baddr;
        logic [7:0]  bstat;
        logic        evalid;
        logic        hit;
        logic [8:0]  cnt;
        logic [31:0] hash;
        logic [8:0]  rem;
    } t_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] new_dst_ip;
        logic [15:0] new_checksum;
        logic [8:0]  be_id;
    } t_result;

    // One FNV-1a word step
    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
        fnv_mix = (h ^ v) * FNV_PRIME;
    endfunction

    // Four restoring-division steps, remainder only
    function automatic logic [8:0] mod_step(input logic [8:0] rem, input logic [3:0] bits,
                                            input logic [8:0] d);
        logic [9:0] t;
        logic [8:0] r;
        r = rem;
        for (int i = 3; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
            end
            r = t[8:0];
        end
        mod_step = r;
    endfunction

    // Incremental IPv4 checksum update for a replaced 32-bit address
    function automatic logic [15:0] csum_swap(input logic [15:0] hc, input logic [31:0] from,
                                              input logic [31:0] to);
        logic [31:0] nf;
        logic [18:0] s;
        logic [16:0] f1;
        logic [16:0] f2;
        nf = ~from;
        s  = {3'b0, ~hc} + {3'b0, nf[31:16]} + {3'b0, nf[15:0]}
           + {3'b0, to[31:16]} + {3'b0, to[15:0]};
        f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
        csum_swap = ~f2[15:0];
    endfunction

endpackage

// ===== hw/rtl/service_backend_selector_unit.sv =====
// ============================================================================
// service_backend_selector_unit
// Service lookup, FNV-1a hash modulo backend selection and address rewrite.
// ============================================================================
// Usage:
//   Items arrive on the slave stream (i_s_*). A classify item carries a
//   5-tuple and checksum; write items (service or backend) update the tables
//   in stream order, so a later classify always sees earlier writes.
//   Every item yields exactly one transfer on the master stream (o_m_*):
//   verdict, new destination address, checksum and backend id.
// Throughput: one item per cycle while the output is not stalled. The pipeline
//   has 15 stages plus an output register; the hash takes five multiplier
//   stages and the modulo by the service's backend count takes eight stages
//   of four bits each. The backend table is a memory with a registered read
//   port in stage 14.
// Stall: when the result is not taken, the whole pipeline holds and
//   o_s_tready drops; nothing is lost or repeated.
// Reset: synchronous, active low; clears all stage valid bits and the valid
//   bits of both tables. No clearing pass is needed.
// ============================================================================
module service_backend_selector_unit
    import sbs_pkg::*;
#(
    parameter int SERVICE_ENTRIES = DEF_SERVICE_ENTRIES,
    parameter int BACKEND_ENTRIES = DEF_BACKEND_ENTRIES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // cmd[1:0] entry_index[9:2] src_ip[41:10] dst_ip[73:42] sport[89:74]
    // dport[105:90] protocol[113:106] ip_checksum[129:114]
    // backend_total[138:130] backend_addr[170:139] backend_status[178:171]
    // entry_valid[179], zero fill above
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // verdict[1:0] new_dst_ip[33:2] new_checksum[49:34] be_id[58:50],
    // zero fill above
    output logic [OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int SV_AW = (SERVICE_ENTRIES > 1) ? $clog2(SERVICE_ENTRIES) : 1;
    localparam int BE_AW = (BACKEND_ENTRIES > 1) ? $clog2(BACKEND_ENTRIES) : 1;

    // Pipeline registers
    t_item   r_p   [N_STG];
    logic    r_vld [N_STG];
    t_item   n_p   [N_STG];
    t_result r_out;
    t_result n_out;
    logic    r_ovld;
    logic    w_adv;

    // Service table
    logic        r_sv_valid [SERVICE_ENTRIES];
    logic [31:0] r_sv_vip   [SERVICE_ENTRIES];
    logic [15:0] r_sv_port  [SERVICE_ENTRIES];
    logic [7:0]  r_sv_proto [SERVICE_ENTRIES];
    logic [8:0]  r_sv_cnt   [SERVICE_ENTRIES];

    // Backend table: valid bits in flops, address and status in memory
    logic        r_be_valid [BACKEND_ENTRIES];
    logic [39:0] r_be_mem   [BACKEND_ENTRIES];
    logic [39:0] r_be_rdata;
    logic        r_be_vbit;

    logic             w_sv_wr;
    logic [SV_AW-1:0] w_sv_addr;
    logic             w_be_wr;
    logic [BE_AW-1:0] w_be_waddr;
    logic [BE_AW-1:0] w_be_raddr;
    logic             w_fwd;

    // Advance whenever the output register is free or being emptied
    assign w_adv      = !r_ovld || i_m_tready;
    assign o_s_tready = w_adv;

    // Table write strobes, taken in pipeline order
    assign w_sv_wr    = r_vld[0] && (r_p[0].cmd == CMD_SVC_WR)
                        && (32'(r_p[0].idx) < SERVICE_ENTRIES);
    assign w_sv_addr  = SV_AW'(r_p[0].idx);
    assign w_be_wr    = r_vld[STG_MOD_END] && (r_p[STG_MOD_END].cmd == CMD_BE_WR)
                        && (32'(r_p[STG_MOD_END].idx) < BACKEND_ENTRIES);
    assign w_be_waddr = BE_AW'(r_p[STG_MOD_END].idx);
    assign w_be_raddr = BE_AW'(r_p[STG_MOD_END].rem);

    // Stage logic
    always_comb begin
        logic [31:0] v;
        logic        fwd;
        // Capture and force ports of classify items for protocols without them
        n_p[0].cmd    = i_s_tdata[1:0];
        n_p[0].idx    = i_s_tdata[9:2];
        n_p[0].sip    = i_s_tdata[41:10];
        n_p[0].dip    = i_s_tdata[73:42];
        n_p[0].proto  = i_s_tdata[113:106];
        n_p[0].hc     = i_s_tdata[129:114];
        n_p[0].total  = i_s_tdata[138:130];
        n_p[0].baddr  = i_s_tdata[170:139];
        n_p[0].bstat  = i_s_tdata[178:171];
        n_p[0].evalid = i_s_tdata[179];
        n_p[0].hit    = 1'b0;
        n_p[0].cnt    = '0;
        n_p[0].hash   = '0;
        n_p[0].rem    = '0;
        fwd = (i_s_tdata[1:0] != CMD_CLASSIFY)
              || (i_s_tdata[113:106] == PROTO_TCP) || (i_s_tdata[113:106] == PROTO_UDP);
        n_p[0].sport  = fwd ? i_s_tdata[89:74] : 16'd0;
        n_p[0].dport  = fwd ? i_s_tdata[105:90] : 16'd0;

        // Match the service table, lowest index wins; first hash mix
        n_p[STG_MATCH] = r_p[0];
        for (int i = SERVICE_ENTRIES - 1; i >= 0; i--) begin
            if (r_sv_valid[i] && (r_sv_vip[i] == r_p[0].dip)
                && (r_sv_port[i] == r_p[0].dport) && (r_sv_proto[i] == r_p[0].proto)) begin
                n_p[STG_MATCH].hit = 1'b1;
                n_p[STG_MATCH].cnt = r_sv_cnt[i];
            end
        end
        n_p[STG_MATCH].hash = fnv_mix(FNV_OFFSET, r_p[0].sip);

        // Remaining hash mixes, one multiplier per stage
        for (int k = STG_MATCH + 1; k <= STG_MIX_END; k++) begin
            n_p[k] = r_p[k-1];
            case (k)
                2:       v = r_p[k-1].dip;
                3:       v = {16'd0, r_p[k-1].sport};
                4:       v = {16'd0, r_p[k-1].dport};
                default: v = {24'd0, r_p[k-1].proto};
            endcase
            n_p[k].hash = fnv_mix(r_p[k-1].hash, v);
        end

        // Modulo by the backend count, four dividend bits per stage
        for (int k = STG_MIX_END + 1; k <= STG_MOD_END; k++) begin
            n_p[k]     = r_p[k-1];
            n_p[k].rem = mod_step(r_p[k-1].rem,
                                  r_p[k-1].hash[31-4*(k-STG_MIX_END-1) -: 4],
                                  r_p[k-1].cnt);
        end

        n_p[STG_READ] = r_p[STG_MOD_END];
        w_fwd = fwd;
    end

    // Verdict and rewrite
    always_comb begin
        t_item it;
        it = r_p[STG_READ];
        n_out.verdict      = VERDICT_PASS;
        n_out.new_dst_ip   = '0;
        n_out.new_checksum = '0;
        n_out.be_id        = '0;
        case (it.cmd)
            CMD_CLASSIFY: begin
                n_out.new_checksum = it.hc;
                if (it.hit) begin
                    if ((it.cnt == 9'd0) || (32'(it.rem) >= BACKEND_ENTRIES) || !r_be_vbit
                        || (r_be_rdata[39:32] != 8'd0)) begin
                        n_out.verdict = VERDICT_DROP;
                    end else begin
                        n_out.verdict      = VERDICT_REWRITE;
                        n_out.new_dst_ip   = r_be_rdata[31:0];
                        n_out.new_checksum = csum_swap(it.hc, it.dip, r_be_rdata[31:0]);
                        n_out.be_id        = it.rem + 9'd1;
                    end
                end
            end
            default: begin
                n_out.verdict = VERDICT_PASS;
            end
        endcase
    end

    // Advance stages, tables and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            for (int k = 0; k < N_STG; k++) begin
                r_vld[k] <= 1'b0;
            end
            for (int i = 0; i < SERVICE_ENTRIES; i++) begin
                r_sv_valid[i] <= 1'b0;
            end
            for (int i = 0; i < BACKEND_ENTRIES; i++) begin
                r_be_valid[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < N_STG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[STG_READ];
            if (w_sv_wr) begin
                r_sv_valid[w_sv_addr] <= r_p[0].evalid;
            end
            if (w_be_wr) begin
                r_be_valid[w_be_waddr] <= r_p[STG_MOD_END].evalid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < N_STG; k++) begin
                r_p[k] <= n_p[k];
            end
            r_out <= n_out;
            if (w_sv_wr) begin
                r_sv_vip[w_sv_addr]   <= r_p[0].dip;
                r_sv_port[w_sv_addr]  <= r_p[0].dport;
                r_sv_proto[w_sv_addr] <= r_p[0].proto;
                r_sv_cnt[w_sv_addr]   <= r_p[0].total;
            end
        end
    end

    // Backend memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_adv && w_be_wr) begin
            r_be_mem[w_be_waddr] <= {r_p[STG_MOD_END].bstat, r_p[STG_MOD_END].baddr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_be_rdata <= r_be_mem[w_be_raddr];
            r_be_vbit  <= r_be_valid[w_be_raddr];
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {5'd0, r_out.be_id, r_out.new_checksum, r_out.new_dst_ip,
                         r_out.verdict};

    // Checks
    a_rewrite_has_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_out.verdict == VERDICT_REWRITE)) |-> (r_out.be_id != 9'd0))
        else $error("rewrite without backend id");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_out.verdict == VERDICT_DROP))
        |-> ((r_out.new_dst_ip == 32'd0) && (r_out.be_id == 9'd0)))
        else $error("drop carries backend fields");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STG_READ] && (r_p[STG_READ].cmd != CMD_CLASSIFY) && w_adv)
        |=> (r_out.verdict == VERDICT_PASS) && (r_out.new_checksum == 16'd0))
        else $error("write item gave nonzero result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_ovld)
        else $error("output valid right after reset");

    a_fwd_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fwd |-> ((n_p[0].sport == 16'd0) && (n_p[0].dport == 16'd0)))
        else $error("ports kept for portless protocol");

endmodule

// ===== dv/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the service backend selector: directed table of
// table writes and classify packets, then random traffic checked against a
// local predictor of service match, FNV-1a hash, modulo slot and checksum.
// ============================================================================
module testbench;
    import sbs_pkg::*;

    localparam int SVC_N    = DEF_SERVICE_ENTRIES;
    localparam int BE_N     = DEF_BACKEND_ENTRIES;
    localparam int SVC_AW   = $clog2(SVC_N);
    localparam int BE_AW    = $clog2(BE_N);
    localparam int WDOG_MAX = 5000;
    localparam int N_RAND   = 1900;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [15:0] hc;
        logic [8:0]  total;
        logic [31:0] baddr;
        logic [7:0]  bstat;
        logic        evalid;
    } t_pkt;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] new_dst_ip;
        logic [15:0] new_checksum;
        logic [8:0]  be_id;
    } t_out;

    // Directed row: item plus optional typed-in result
    typedef struct {
        t_pkt pkt;
        bit   fixed;
        t_out res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // cmd, entry_index, src_ip, dst_ip, sport, dport, protocol,
    // ip_checksum, backend_total, backend_addr, backend_status, entry_valid
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // verdict, new_dst_ip, new_checksum, be_id
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    service_backend_selector_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    // Predictor copy of the tables
    logic        svc_valid [SVC_N];
    logic [31:0] svc_vip   [SVC_N];
    logic [15:0] svc_port  [SVC_N];
    logic [7:0]  svc_proto [SVC_N];
    logic [8:0]  svc_count [SVC_N];
    logic        be_valid  [BE_N];
    logic [31:0] be_addr   [BE_N];
    logic [7:0]  be_stat   [BE_N];

    t_out  pending_results[$];
    int    mismatches = 0;
    int    n_results = 0;
    int    n_rewrite = 0;
    int    n_drop = 0;
    int    idle_in = 0;
    int    idle_out = 0;
    int    wdog = 0;
    bit    timed_out = 0;

    function automatic logic [15:0] swap_sum(logic [15:0] hc, logic [31:0] from,
                                             logic [31:0] to);
        logic [31:0] nf;
        logic [31:0] s;
        nf = ~from;
        s = {16'd0, ~hc} + nf[31:16] + nf[15:0] + to[31:16] + to[15:0];
        s = s[15:0] + (s >> 16);
        s = s[15:0] + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic logic [31:0] hash_word(logic [31:0] h, logic [31:0] v);
        return (h ^ v) * 32'd16777619;
    endfunction

    // Work out the expected result and apply table writes
    function automatic t_out select_backend(t_pkt p);
        t_out r;
        int hit;
        logic [31:0] h;
        logic [31:0] slot;
        logic [BE_AW-1:0] si;
        logic [15:0] sp;
        logic [15:0] dp;
        r = '0;
        hit = -1;
        if (p.cmd == CMD_SVC_WR) begin
            if (p.idx < SVC_N) begin
                svc_valid[p.idx[SVC_AW-1:0]] = p.evalid;
                svc_vip[p.idx[SVC_AW-1:0]] = p.dip;
                svc_port[p.idx[SVC_AW-1:0]] = p.dport;
                svc_proto[p.idx[SVC_AW-1:0]] = p.proto;
                svc_count[p.idx[SVC_AW-1:0]] = p.total;
            end
            return r;
        end
        if (p.cmd == CMD_BE_WR) begin
            if (p.idx < BE_N) begin
                be_valid[p.idx[BE_AW-1:0]] = p.evalid;
                be_addr[p.idx[BE_AW-1:0]] = p.baddr;
                be_stat[p.idx[BE_AW-1:0]] = p.bstat;
            end
            return r;
        end
        if (p.cmd != CMD_CLASSIFY) return r;
        sp = p.sport;
        dp = p.dport;
        if (p.proto != PROTO_TCP && p.proto != PROTO_UDP) begin
            sp = '0;
            dp = '0;
        end
        r.new_checksum = p.hc;
        for (int i = SVC_N - 1; i >= 0; i--)
            if (svc_valid[i] && svc_vip[i] == p.dip && svc_port[i] == dp
                && svc_proto[i] == p.proto) hit = i;
        if (hit < 0) return r;
        if (svc_count[hit] == 0) begin
            r.verdict = VERDICT_DROP;
            return r;
        end
        h = 32'd2166136261;
        h = hash_word(h, p.sip);
        h = hash_word(h, p.dip);
        h = hash_word(h, {16'd0, sp});
        h = hash_word(h, {16'd0, dp});
        h = hash_word(h, {24'd0, p.proto});
        slot = h % svc_count[hit];
        si = slot[BE_AW-1:0];
        if (slot >= BE_N || !be_valid[si] || be_stat[si] != 0) begin
            r.verdict = VERDICT_DROP;
            return r;
        end
        r.verdict = VERDICT_REWRITE;
        r.new_dst_ip = be_addr[si];
        r.new_checksum = swap_sum(p.hc, p.dip, be_addr[si]);
        r.be_id = 9'(slot + 1);
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_item(t_pkt p);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[1:0] = p.cmd;      d[9:2] = p.idx;        d[41:10] = p.sip;
        d[73:42] = p.dip;    d[89:74] = p.sport;    d[105:90] = p.dport;
        d[113:106] = p.proto; d[129:114] = p.hc;    d[138:130] = p.total;
        d[170:139] = p.baddr; d[178:171] = p.bstat; d[179] = p.evalid;
        return d;
    endfunction

    function automatic t_pkt rand_pkt();
        t_pkt p;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(t_pkt)-1:0];
        return p;
    endfunction

    // Small pools of VIPs, ports and protocols so random packets hit services
    logic [31:0] vip_pool [4] = '{32'h0A000001, 32'hC0A80A0A, 32'hFFFFFFFF, 32'h0};
    logic [15:0] port_pool [4] = '{16'd80, 16'd443, 16'hFFFF, 16'd0};
    logic [7:0]  proto_pool [4] = '{PROTO_TCP, PROTO_UDP, 8'd1, 8'd255};

    function automatic t_pkt shaped_pkt();
        t_pkt p;
        int k;
        p = rand_pkt();
        k = $urandom_range(0, 99);
        if (k < 8) begin
            p.cmd = CMD_SVC_WR;
            p.idx = ($urandom_range(0, 9) == 0) ? p.idx : 8'($urandom_range(0, SVC_N - 1));
            p.dip = vip_pool[$urandom_range(0, 3)];
            p.dport = port_pool[$urandom_range(0, 3)];
            p.proto = proto_pool[$urandom_range(0, 3)];
            if (p.proto != PROTO_TCP && p.proto != PROTO_UDP && $urandom_range(0, 3) != 0)
                p.dport = '0;
            p.evalid = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 5) != 0) p.total = 9'($urandom_range(1, 12));
        end else if (k < 22) begin
            p.cmd = CMD_BE_WR;
            if ($urandom_range(0, 3) != 0) p.idx = 8'($urandom_range(0, 15));
            if ($urandom_range(0, 3) != 0) p.bstat = '0;
            p.evalid = ($urandom_range(0, 5) != 0);
        end else if (k < 24) begin
            p.cmd = CMD_NONE;
        end else begin
            p.cmd = CMD_CLASSIFY;
            if ($urandom_range(0, 9) != 0) begin
                p.dip = vip_pool[$urandom_range(0, 3)];
                p.dport = port_pool[$urandom_range(0, 3)];
                p.proto = proto_pool[$urandom_range(0, 3)];
            end
        end
        return p;
    endfunction

    function automatic t_pkt mk(logic [1:0] c, logic [7:0] ix, logic [31:0] dip,
                                logic [15:0] dport, logic [7:0] pr, logic [8:0] tot,
                                logic [31:0] ba, logic [7:0] bs, logic ev);
        t_pkt p;
        p = '0;
        p.cmd = c; p.idx = ix; p.dip = dip; p.dport = dport; p.proto = pr;
        p.total = tot; p.baddr = ba; p.bstat = bs; p.evalid = ev;
        p.sip = 32'h01020304; p.sport = 16'd1234; p.hc = 16'hB1E6;
        return p;
    endfunction

    // Idle percentages of the current phase
    always @(posedge i_clk) begin
        if (i_rst_n) i_m_tready <= ($urandom_range(0, 99) >= idle_out);
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_out got;
        t_out exp_r;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[1:0], o_m_tdata[33:2], o_m_tdata[49:34],
                       o_m_tdata[58:50]};
                n_results++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %h %h %0d got %0d %h %h %0d",
                                     exp_r.verdict, exp_r.new_dst_ip, exp_r.new_checksum,
                                     exp_r.be_id, got.verdict, got.new_dst_ip,
                                     got.new_checksum, got.be_id);
                    end
                    if (exp_r.verdict == VERDICT_REWRITE) n_rewrite++;
                    if (exp_r.verdict == VERDICT_DROP) n_drop++;
                end
            end
        end
    end

    // Watchdog on stalled traffic
    always @(posedge i_clk) begin
        if (wdog >= WDOG_MAX && !timed_out) begin
            timed_out = 1;
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(t_pkt p, bit fixed, t_out res);
        t_out pred;
        while ($urandom_range(0, 99) < idle_in) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pack_item(p);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = select_backend(p);
        if (fixed && pred !== res) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row disagrees with predictor");
        end
        pending_results.push_back(fixed ? res : pred);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    t_row rows[$];

    initial begin
        t_pkt p;
        t_out none;
        none = '0;
        for (int i = 0; i < SVC_N; i++) begin
            svc_valid[i] = 0; svc_vip[i] = 0; svc_port[i] = 0;
            svc_proto[i] = 0; svc_count[i] = 0;
        end
        for (int i = 0; i < BE_N; i++) begin
            be_valid[i] = 0; be_addr[i] = 0; be_stat[i] = 0;
        end

        // Directed rows: empty tables, writes, extremes and drop reasons
        p = mk(CMD_CLASSIFY, 0, 32'h0A000001, 80, PROTO_TCP, 0, 0, 0, 0);
        rows.push_back('{p, 1, t_out'{VERDICT_PASS, 32'd0, 16'hB1E6, 9'd0}});
        p = mk(CMD_SVC_WR, 0, 32'h0A000001, 80, PROTO_TCP, 1, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'h0A000001, 80, PROTO_TCP, 0, 0, 0, 0);
        rows.push_back('{p, 1, t_out'{VERDICT_DROP, 32'd0, 16'hB1E6, 9'd0}});
        p = mk(CMD_BE_WR, 0, 0, 0, 0, 0, 32'hC0A80002, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'h0A000001, 80, PROTO_TCP, 0, 0, 0, 0);
        rows.push_back('{p, 0, none});
        p = mk(CMD_BE_WR, 0, 0, 0, 0, 0, 32'hC0A80002, 8'hFF, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'h0A000001, 80, PROTO_TCP, 0, 0, 0, 0);
        rows.push_back('{p, 1, t_out'{VERDICT_DROP, 32'd0, 16'hB1E6, 9'd0}});
        // Zero count, lower index wins, ports forced on non-TCP/UDP
        p = mk(CMD_SVC_WR, 1, 32'hFFFFFFFF, 0, 8'd1, 0, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'hFFFFFFFF, 16'hFFFF, 8'd1, 0, 0, 0, 0);
        rows.push_back('{p, 1, t_out'{VERDICT_DROP, 32'd0, 16'hB1E6, 9'd0}});
        p = mk(CMD_SVC_WR, 2, 32'hFFFFFFFF, 0, 8'd1, 9'd511, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_SVC_WR, 1, 32'hFFFFFFFF, 0, 8'd1, 9'd256, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_BE_WR, 8'd255, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'hFFFFFFFF, 16'h1, 8'd1, 0, 0, 0, 0);
        rows.push_back('{p, 0, none});
        p = mk(CMD_SVC_WR, 1, 32'hFFFFFFFF, 0, 8'd1, 9'd511, 0, 0, 0);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'hFFFFFFFF, 16'h0, 8'd1, 0, 0, 0, 0);
        rows.push_back('{p, 0, none});
        // Service with port on a portless protocol never matches
        p = mk(CMD_SVC_WR, 3, 32'h0, 16'd53, 8'd255, 1, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'h0, 16'd53, 8'd255, 0, 0, 0, 0);
        rows.push_back('{p, 1, t_out'{VERDICT_PASS, 32'd0, 16'hB1E6, 9'd0}});
        // Out-of-range service index, unused command
        p = mk(CMD_SVC_WR, 8'd200, 32'h0, 16'd53, PROTO_UDP, 1, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'h0, 16'd53, PROTO_UDP, 0, 0, 0, 0);
        rows.push_back('{p, 1, t_out'{VERDICT_PASS, 32'd0, 16'hB1E6, 9'd0}});
        p = mk(CMD_NONE, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 9'h1FF, 32'hFFFFFFFF, 8'hFF, 1);
        p.sip = '1; p.sport = '1; p.hc = '1;
        rows.push_back('{p, 1, none});
        p = mk(CMD_SVC_WR, 4, 32'h0, 16'hFFFF, PROTO_UDP, 1, 0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_BE_WR, 0, 0, 0, 0, 0, 32'h0, 0, 1);
        rows.push_back('{p, 1, none});
        p = mk(CMD_CLASSIFY, 0, 32'h0, 16'hFFFF, PROTO_UDP, 0, 0, 0, 0);
        p.hc = 16'h0000;
        rows.push_back('{p, 0, none});
        p.hc = 16'hFFFF; p.sip = '1; p.sport = '1;
        rows.push_back('{p, 0, none});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_in = 28;
        idle_out = 45;
        foreach (rows[i]) send_item(rows[i].pkt, rows[i].fixed, rows[i].res);

        // Random traffic in three idling phases
        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 3) begin
                idle_in = 45;
                idle_out = 28;
            end
            if (n == 2 * N_RAND / 3) begin
                drain();
                idle_in = 0;
                idle_out = 0;
            end
            send_item(shaped_pkt(), 0, none);
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d items: %0d rewrites, %0d drops, table writes and extremes",
                 n_results, n_rewrite, n_drop);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule
